/* rtl/core/lfade_pkg.sv */
// Shared types and constants of the linear luma fade core.
// Used by every module under rtl/core; depends on nothing else.
package lfade_pkg;

  localparam int unsigned FRAME_W   = 24;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned Q_W       = 8;
  localparam int unsigned NUM_W     = 36;
  localparam int unsigned DIV_W     = 28;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned WEIGHT_SCALE = 2550;
  localparam int unsigned WEIGHT_BIAS  = 4;
  localparam int unsigned SPAN_SCALE   = 10;
  localparam int unsigned PIX_MAX      = 255;
  localparam int unsigned ROUND_BIAS   = 102;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_FRAME,
    CFG_END_FRAME,
    CFG_FADE_IN
  } cfg_idx_e;

  typedef struct packed {
    logic [FRAME_W-1:0] start_frame;
    logic [FRAME_W-1:0] end_frame;
    logic               fade_in;
  } cfg_t;

  // Payload carried through the weight divider.
  typedef struct packed {
    logic             pass;
    logic [PIX_W-1:0] pixel;
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] den;
    logic [Q_W-1:0]   quo;
  } div_t;

endpackage

/* rtl/core/lfade_front.sv */
// Front end of the fade core: range check, then numerator and divisor of the weight.
// Two register stages; depends on lfade_pkg.
module lfade_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfade_pkg::cfg_t               cfg_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [lfade_pkg::FRAME_W-1:0] frame_number_i,
  input  logic [lfade_pkg::PIX_W-1:0]   pixel_in_i,
  input  logic                          is_chroma_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output lfade_pkg::div_t               data_o
);

  localparam int unsigned NumW   = lfade_pkg::NUM_W;
  localparam int unsigned DivW   = lfade_pkg::DIV_W;
  localparam int unsigned FrameW = lfade_pkg::FRAME_W;
  localparam int unsigned PixW   = lfade_pkg::PIX_W;

  logic              v1_q, v2_q;
  logic              ready1, ready2;
  logic              pass_d, pass_q;
  logic [FrameW-1:0] pos_d, pos_q;
  logic [FrameW-1:0] span_d, span_q;
  logic [PixW-1:0]   pix_q;
  lfade_pkg::div_t   data_d, data_q;

  assign ready2  = !v2_q || !stall_i;
  assign ready1  = !v1_q || ready2;
  assign stall_o = !ready1;

  // A luma sample inside a non-empty range is faded; everything else passes.
  always_comb begin
    pass_d = is_chroma_i
          || (frame_number_i < cfg_i.start_frame)
          || (frame_number_i > cfg_i.end_frame)
          || (cfg_i.start_frame == cfg_i.end_frame);
    pos_d  = frame_number_i - cfg_i.start_frame;
    span_d = cfg_i.end_frame - cfg_i.start_frame;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && valid_i) begin
      pass_q <= pass_d;
      pos_q  <= pos_d;
      span_q <= span_d;
      pix_q  <= pixel_in_i;
    end
  end

  always_comb begin
    data_d.pass  = pass_q;
    data_d.pixel = pix_q;
    data_d.num   = NumW'(pos_q) * NumW'(lfade_pkg::WEIGHT_SCALE)
                 + NumW'(span_q) * NumW'(lfade_pkg::WEIGHT_BIAS);
    data_d.den   = DivW'(span_q) * DivW'(lfade_pkg::SPAN_SCALE);
    data_d.quo   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/lfade_div_step.sv */
// One restoring step of the weight divider: decides quotient bit BIT.
// One register stage; depends on lfade_pkg.
module lfade_div_step #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  lfade_pkg::div_t data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output lfade_pkg::div_t data_o
);

  localparam int unsigned NumW = lfade_pkg::NUM_W;
  localparam int unsigned DivW = lfade_pkg::DIV_W;

  logic            v_q;
  logic            ready;
  logic            take;
  logic [NumW-1:0] shifted;
  lfade_pkg::div_t data_d, data_q;

  assign ready   = !v_q || !stall_i;
  assign stall_o = !ready;

  always_comb begin
    shifted        = {{(NumW-DivW){1'b0}}, data_i.den} << BIT;
    take           = data_i.num >= shifted;
    data_d         = data_i;
    data_d.num     = take ? (data_i.num - shifted) : data_i.num;
    data_d.quo[BIT] = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;

  // For a faded item the partial remainder must stay below the divisor at this weight.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !data_o.pass |->
      data_o.num < ({{(NumW-DivW){1'b0}}, data_o.den} << BIT))
    else $error("divider remainder out of bound");

endmodule

/* rtl/core/lfade_scale.sv */
// Gain stage of the fade core: gain select and multiply, division by 255, output register.
// Three register stages; depends on lfade_pkg.
module lfade_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fade_in_i,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  lfade_pkg::div_t             data_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [lfade_pkg::PIX_W-1:0] pixel_o
);

  localparam int unsigned PixW  = lfade_pkg::PIX_W;
  localparam int unsigned ProdW = 2 * lfade_pkg::PIX_W;

  logic             va_q, vb_q, vc_q;
  logic             ready_a, ready_b, ready_c;
  logic [PixW-1:0]  gain;
  logic [ProdW-1:0] prod_d, prod_q;
  logic             pass_a_q, pass_b_q;
  logic [PixW-1:0]  pix_a_q, pix_b_q;
  logic [ProdW-1:0] y_d, y_q;
  logic [ProdW-1:0] est_sum;
  logic [PixW-1:0]  est_q;
  logic [ProdW-1:0] rem;
  logic [PixW-1:0]  quot;
  logic [PixW-1:0]  pixel_d, pixel_q;

  assign ready_c = !vc_q || !stall_i;
  assign ready_b = !vb_q || ready_c;
  assign ready_a = !va_q || ready_b;
  assign stall_o = !ready_a;

  always_comb begin
    gain   = fade_in_i ? data_i.quo : (PixW'(lfade_pkg::PIX_MAX) - data_i.quo);
    prod_d = ProdW'(data_i.pixel) * ProdW'(gain);
  end

  // The estimate (y + y/256) / 256 is the true quotient or one below it.
  always_comb begin
    y_d     = prod_q + ProdW'(lfade_pkg::ROUND_BIAS);
    est_sum = y_d + {{PixW{1'b0}}, y_d[ProdW-1:PixW]};
  end

  always_comb begin
    rem     = y_q - ProdW'(est_q) * ProdW'(lfade_pkg::PIX_MAX);
    quot    = (rem >= ProdW'(lfade_pkg::PIX_MAX)) ? (est_q + PixW'(1)) : est_q;
    pixel_d = pass_b_q ? pix_b_q : quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
      if (ready_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      prod_q   <= prod_d;
      pass_a_q <= data_i.pass;
      pix_a_q  <= data_i.pixel;
    end
    if (ready_b && va_q) begin
      y_q      <= y_d;
      est_q    <= est_sum[ProdW-1:PixW];
      pass_b_q <= pass_a_q;
      pix_b_q  <= pix_a_q;
    end
    if (ready_c && vb_q) begin
      pixel_q  <= pixel_d;
    end
  end

  assign valid_o = vc_q;
  assign pixel_o = pixel_q;

  a_est_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && !pass_b_q |->
      (y_q - ProdW'(est_q) * ProdW'(lfade_pkg::PIX_MAX)) < ProdW'(2 * lfade_pkg::PIX_MAX))
    else $error("quotient estimate more than one below");

endmodule

/* rtl/core/luma_linear_fade_core.sv */
// Items pass the front end, the divider steps and the gain stage to the output register.
// Throughput: one item per cycle unless the output stalls; the divider takes one quotient
// bit per stage over eight stages, and every stage has its own valid bit, so bubbles close up under stall.
// Reset clears all valid bits and the configuration registers (start 0, end 0, fade-out).
// Top level of the linear luma fade; depends on lfade_pkg, lfade_front,
// lfade_div_step and lfade_scale.
module luma_linear_fade_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfade_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lfade_pkg::FRAME_W-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lfade_pkg::FRAME_W-1:0]   frame_number_i,
  input  logic [lfade_pkg::PIX_W-1:0]     pixel_in_i,
  input  logic                            is_chroma_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lfade_pkg::PIX_W-1:0]     pixel_out_o
);

  localparam int unsigned QW = lfade_pkg::Q_W;

  lfade_pkg::cfg_t cfg_q;
  lfade_pkg::div_t chain_data [0:QW];
  logic            chain_valid [0:QW];
  logic            chain_stall [0:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lfade_pkg::CFG_START_FRAME: cfg_q.start_frame <= cfg_data_i;
        lfade_pkg::CFG_END_FRAME:   cfg_q.end_frame   <= cfg_data_i;
        lfade_pkg::CFG_FADE_IN:     cfg_q.fade_in     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lfade_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .valid_i        (in_valid_i),
    .stall_o        (in_stall_o),
    .frame_number_i (frame_number_i),
    .pixel_in_i     (pixel_in_i),
    .is_chroma_i    (is_chroma_i),
    .valid_o        (chain_valid[0]),
    .stall_i        (chain_stall[0]),
    .data_o         (chain_data[0])
  );

  // Most significant quotient bit first.
  for (genvar g = 0; g < QW; g++) begin : g_div
    lfade_div_step #(
      .BIT (QW - 1 - g)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .stall_o (chain_stall[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .stall_i (chain_stall[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  lfade_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fade_in_i (cfg_q.fade_in),
    .valid_i   (chain_valid[QW]),
    .stall_o   (chain_stall[QW]),
    .data_i    (chain_data[QW]),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .pixel_o   (pixel_out_o)
  );

  // The input can only be held off when every stage is full and the output is stalled.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline has room");

endmodule
